[design/vtce_pkg.sv]
// Shared types and byte constants for the vector terminal coordinate encoder.
package vtce_pkg;

    typedef enum logic [2:0] {
        ACT_DRAW  = 3'd0,
        ACT_MOVE  = 3'd1,
        ACT_ALPHA = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_PLOT  = 3'd4
    } action_t;

    localparam int MAX_BYTES   = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [9:0] X_MAX = 10'd1023;
    localparam logic [9:0] Y_MAX = 10'd767;

    localparam logic [6:0] TAG_HIGH  = 7'h20;  // 0040
    localparam logic [6:0] TAG_LOW_Y = 7'h60;  // 0140
    localparam logic [6:0] TAG_LOW_X = 7'h40;  // 0100
    localparam logic [6:0] CH_US     = 7'h1F;  // 037
    localparam logic [6:0] CH_GS     = 7'h1D;  // 035
    localparam logic [6:0] CH_ESC    = 7'h1B;  // 033
    localparam logic [6:0] CH_FF     = 7'h0C;  // 014
    localparam logic [6:0] CH_AT     = 7'h40;  // '@'

    // One command worth of bytes, packed from entry 0 upward.
    typedef struct packed {
        logic [2:0]                 count;
        logic [MAX_BYTES-1:0][6:0]  bytes;
    } job_t;

endpackage

[design/vtce_front.sv]
// Front end: accepts commands, clamps coordinates and builds the byte list.
module vtce_front
    import vtce_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [2:0]  action,
    input  logic [15:0] x,
    input  logic [15:0] y,
    input  logic        q_full,
    output logic        in_stall,
    output logic        push,
    output job_t        push_job
);

    logic [6:0] prev_hy_reg, prev_ly_reg, prev_hx_reg;
    logic [6:0] prev_hy_next, prev_ly_next, prev_hx_next;

    logic [9:0] xc, yc;
    logic [6:0] hy, ly, hx, lx;
    logic       hy_chg, hx_chg;
    logic       known;
    logic       accept;
    logic [MAX_BYTES-1:0][6:0] cand;
    logic [MAX_BYTES-1:0]      en;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && known;

    always_comb
    begin
        if (x[15])
            xc = 10'd0;
        else if (x[14:0] > {5'd0, X_MAX})
            xc = X_MAX;
        else
            xc = x[9:0];
        if (y[15])
            yc = 10'd0;
        else if (y[14:0] > {5'd0, Y_MAX})
            yc = Y_MAX;
        else
            yc = y[9:0];
    end

    assign hy     = TAG_HIGH  | {2'b00, yc[9:5]};
    assign ly     = TAG_LOW_Y | {2'b00, yc[4:0]};
    assign hx     = TAG_HIGH  | {2'b00, xc[9:5]};
    assign lx     = TAG_LOW_X | {2'b00, xc[4:0]};
    assign hy_chg = hy != prev_hy_reg;
    assign hx_chg = hx != prev_hx_reg;

    always_comb
    begin
        cand         = '0;
        en           = '0;
        known        = 1'b1;
        prev_hy_next = prev_hy_reg;
        prev_ly_next = prev_ly_reg;
        prev_hx_next = prev_hx_reg;
        case (action)
            ACT_DRAW, ACT_MOVE:
            begin
                cand = {lx, hx, ly, hy, CH_GS};
                en   = {1'b1, hx_chg, (ly != prev_ly_reg) || hx_chg, hy_chg,
                        action == ACT_MOVE};
                prev_hy_next = hy;
                prev_ly_next = ly;
                prev_hx_next = hx;
            end
            ACT_ALPHA:
            begin
                cand[0] = CH_US;
                en[0]   = 1'b1;
            end
            ACT_CLEAR:
            begin
                cand[0] = CH_ESC;
                cand[1] = CH_FF;
                en[1:0] = 2'b11;
            end
            ACT_PLOT:
            begin
                cand[0] = CH_GS;
                cand[1] = CH_AT;
                en[1:0] = 2'b11;
                prev_hy_next = '0;
                prev_ly_next = '0;
                prev_hx_next = '0;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    // Pack the enabled bytes to the bottom of the list.
    always_comb
    begin
        logic [2:0] cnt;
        cnt      = 3'd0;
        push_job = '0;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (en[i])
            begin
                push_job.bytes[cnt] = cand[i];
                cnt = cnt + 3'd1;
            end
        end
        push_job.count = cnt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_hy_reg <= '0;
            prev_ly_reg <= '0;
            prev_hx_reg <= '0;
        end
        else if (push)
        begin
            prev_hy_reg <= prev_hy_next;
            prev_ly_reg <= prev_ly_next;
            prev_hx_reg <= prev_hx_next;
        end
    end

endmodule

[design/vtce_fifo.sv]
// Short queue of byte lists between the front end and the byte sender.
module vtce_fifo
    import vtce_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic q_valid,
    output job_t q_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full    = fill_reg == CNT_W'(DEPTH);
    assign q_valid = fill_reg != '0;
    assign q_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                fill_reg <= fill_reg + CNT_W'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - CNT_W'(1);
        end
    end

endmodule

[design/vtce_back.sv]
// Back end: sends the queued bytes one per cycle while out_stall is low, through an output register.
module vtce_back
    import vtce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  job_t       q_job,
    output logic       pop,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [6:0] out_byte,
    output logic       last
);

    job_t       job_reg;
    logic       job_valid_reg;
    logic [2:0] idx_reg;
    logic       out_valid_reg, last_reg;
    logic [6:0] out_byte_reg;

    logic adv, emit, last_now, done;

    assign adv      = !out_valid_reg || !out_stall;
    assign emit     = job_valid_reg && adv;
    assign last_now = idx_reg == (job_reg.count - 3'd1);
    assign done     = emit && last_now;
    // Load the next list when idle, or while the final byte of this one goes out.
    assign pop      = q_valid && (!job_valid_reg || done);

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_job;
        if (emit)
        begin
            out_byte_reg <= job_reg.bytes[idx_reg];
            last_reg     <= last_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                job_valid_reg <= 1'b1;
            else if (done)
                job_valid_reg <= 1'b0;

            if (pop)
                idx_reg <= '0;
            else if (emit)
                idx_reg <= idx_reg + 3'd1;

            if (adv)
                out_valid_reg <= emit;
        end
    end

endmodule

[design/vector_terminal_coordinate_encoder_unit.sv]
// Top level of the vector terminal coordinate encoder.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-------------------------------
//  command | in        | in_valid / in_stall | action[2:0], x[15:0], y[15:0]
//  byte    | out       | out_valid/out_stall | out_byte[6:0], last
//
// A command yields up to five bytes (five only for a move), none for an
// undefined action, sent one per cycle while out_stall is low, so the byte
// port sets the rate. Bytes pass through the queue slot, the list register
// and the output register. The queue holds DEPTH byte lists, so commands
// keep coming in while the output is stalled until it fills. Reset clears
// the stored address bytes, the queue and the output valid flag.
module vector_terminal_coordinate_encoder_unit
    import vtce_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [15:0] x,
    input  logic [15:0] y,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  out_byte,
    output logic        last
);

    logic push, pop, q_full, q_valid;
    job_t push_job, q_job;

    vtce_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .x        (x),
        .y        (y),
        .q_full   (q_full),
        .in_stall (in_stall),
        .push     (push),
        .push_job (push_job)
    );

    vtce_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .q_job    (q_job)
    );

    vtce_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (q_job),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule

[bench/vector_terminal_coordinate_encoder_unit_test.sv]
// Self-checking bench for the vector terminal coordinate encoder: directed table, then random.
module vector_terminal_coordinate_encoder_unit_test;
    import vtce_pkg::*;

    localparam int IDLE_PCT     = 22;
    localparam int RAND_ITEMS   = 450;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    // Action codes that the block ignores
    localparam logic [2:0] ACT_SPARE_5 = 3'd5;
    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;

    localparam logic [6:0] NO_BYTE = 7'h00;

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } term_byte_t;

    // typed_ok rows carry their byte list, first byte in the top entry
    typedef struct packed {
        logic [2:0]       act;
        logic [15:0]      xv;
        logic [15:0]      yv;
        logic             typed_ok;
        logic [2:0]       n_typed;
        logic [4:0][6:0]  typed;
    } plot_row_t;

    localparam int NROWS = 25;
    localparam plot_row_t PLOT_ROWS [NROWS] = '{
        '{ACT_DRAW,    16'd0,     16'd0,     1'b1, 3'd4,
          {TAG_HIGH, TAG_LOW_Y, TAG_HIGH, TAG_LOW_X, NO_BYTE}},
        '{ACT_DRAW,    16'd0,     16'd0,     1'b1, 3'd1,
          {TAG_LOW_X, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE}},
        '{ACT_DRAW,    16'd1023,  16'd767,   1'b1, 3'd4,
          {7'h37, 7'h7F, 7'h3F, 7'h5F, NO_BYTE}},
        '{ACT_DRAW,    16'h7FFF,  16'h7FFF,  1'b1, 3'd1,
          {7'h5F, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE}},
        '{ACT_DRAW,    16'h8000,  16'hFFFF,  1'b1, 3'd4,
          {TAG_HIGH, TAG_LOW_Y, TAG_HIGH, TAG_LOW_X, NO_BYTE}},
        '{ACT_ALPHA,   16'h1234,  16'hFEDC,  1'b1, 3'd1,
          {CH_US, NO_BYTE, NO_BYTE, NO_BYTE, NO_BYTE}},
        '{ACT_CLEAR,   16'hFFFF,  16'h0000,  1'b1, 3'd2,
          {CH_ESC, CH_FF, NO_BYTE, NO_BYTE, NO_BYTE}},
        '{ACT_SPARE_5, 16'd100,   16'd100,   1'b1, 3'd0, '0},
        '{ACT_PLOT,    16'h5555,  16'hAAAA,  1'b1, 3'd2,
          {CH_GS, CH_AT, NO_BYTE, NO_BYTE, NO_BYTE}},
        '{ACT_MOVE,    16'd0,     16'd0,     1'b1, 3'd5,
          {CH_GS, TAG_HIGH, TAG_LOW_Y, TAG_HIGH, TAG_LOW_X}},
        '{ACT_SPARE_6, 16'hFFFF,  16'hFFFF,  1'b1, 3'd0, '0},
        '{ACT_MOVE,    16'd1023,  16'd0,     1'b1, 3'd4,
          {CH_GS, 7'h60, 7'h3F, 7'h5F, NO_BYTE}},
        '{ACT_SPARE_7, 16'h0000,  16'h7FFF,  1'b1, 3'd0, '0},
        '{ACT_DRAW,    16'd1023,  16'd5,     1'b0, 3'd0, '0},
        '{ACT_DRAW,    16'd1024,  16'd768,   1'b0, 3'd0, '0},
        '{ACT_DRAW,    16'hFFFF,  16'h0300,  1'b0, 3'd0, '0},
        '{ACT_MOVE,    16'd31,    16'd31,    1'b0, 3'd0, '0},
        '{ACT_DRAW,    16'd32,    16'd32,    1'b0, 3'd0, '0},
        '{ACT_DRAW,    16'd32,    16'd33,    1'b0, 3'd0, '0},
        '{ACT_ALPHA,   16'h5555,  16'hAAAA,  1'b0, 3'd0, '0},
        '{ACT_PLOT,    16'd0,     16'd0,     1'b0, 3'd0, '0},
        '{ACT_DRAW,    16'd1023,  16'd767,   1'b0, 3'd0, '0},
        '{ACT_CLEAR,   16'd0,     16'd0,     1'b0, 3'd0, '0},
        '{ACT_MOVE,    16'h7FFF,  16'h8000,  1'b0, 3'd0, '0},
        '{ACT_DRAW,    16'd100,   16'd766,   1'b0, 3'd0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  action = ACT_DRAW;
    logic [15:0] x = '0;
    logic [15:0] y = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [6:0]  out_byte;
    logic        last;

    logic        quiet = 1'b0;
    int          mismatches = 0;
    int          byte_count = 0;
    int          cycle_count = 0;

    logic [6:0]  sent_high_y = '0;
    logic [6:0]  sent_low_y = '0;
    logic [6:0]  sent_high_x = '0;
    logic [6:0]  cmd_bytes [$];
    term_byte_t  pending_bytes [$];

    vector_terminal_coordinate_encoder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .x         (x),
        .y         (y),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [9:0] clamp_axis(input logic [15:0] raw, input logic [9:0] lim);
        if (raw[15])
            return '0;
        if (raw > {6'b0, lim})
            return lim;
        return raw[9:0];
    endfunction

    // Byte list of one command; updates the stored address bytes
    function automatic void encode_command(input logic [2:0] act, input logic [15:0] xr,
                                           input logic [15:0] yr);
        logic [9:0] cx;
        logic [9:0] cy;
        logic [6:0] hy;
        logic [6:0] ly;
        logic [6:0] hx;
        logic [6:0] lx;
        cmd_bytes.delete();
        cx = clamp_axis(xr, X_MAX);
        cy = clamp_axis(yr, Y_MAX);
        hy = TAG_HIGH | {2'b0, cy[9:5]};
        ly = TAG_LOW_Y | {2'b0, cy[4:0]};
        hx = TAG_HIGH | {2'b0, cx[9:5]};
        lx = TAG_LOW_X | {2'b0, cx[4:0]};
        case (act)
            ACT_DRAW, ACT_MOVE:
            begin
                if (act == ACT_MOVE)
                    cmd_bytes.push_back(CH_GS);
                if (hy != sent_high_y)
                    cmd_bytes.push_back(hy);
                if (ly != sent_low_y || hx != sent_high_x)
                    cmd_bytes.push_back(ly);
                if (hx != sent_high_x)
                    cmd_bytes.push_back(hx);
                cmd_bytes.push_back(lx);
                sent_high_y = hy;
                sent_low_y  = ly;
                sent_high_x = hx;
            end
            ACT_ALPHA:
                cmd_bytes.push_back(CH_US);
            ACT_CLEAR:
            begin
                cmd_bytes.push_back(CH_ESC);
                cmd_bytes.push_back(CH_FF);
            end
            ACT_PLOT:
            begin
                cmd_bytes.push_back(CH_GS);
                cmd_bytes.push_back(CH_AT);
                sent_high_y = '0;
                sent_low_y  = '0;
                sent_high_x = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [15:0] pick_coord(input logic [15:0] prev, input logic [9:0] lim);
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 5)
            return prev + 16'($urandom_range(0, 64)) - 16'd32;
        if (mode < 8)
            return 16'($urandom_range(0, 32'(lim)));
        return 16'($urandom);
    endfunction

    // Present one command, hold it until the transfer, then queue its bytes
    task automatic issue_command(input logic [2:0] act_v, input logic [15:0] xv,
                                 input logic [15:0] yv, input logic typed_ok,
                                 input logic [2:0] n_typed, input logic [4:0][6:0] typed);
        term_byte_t tb;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act_v;
        x        <= xv;
        y        <= yv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        encode_command(act_v, xv, yv);
        if (typed_ok)
        begin
            cmd_bytes.delete();
            for (int k = 0; k < n_typed; k++)
                cmd_bytes.push_back(typed[4 - k]);
        end
        foreach (cmd_bytes[k])
        begin
            tb.code = cmd_bytes[k];
            tb.last = (k == cmd_bytes.size() - 1);
            pending_bytes.push_back(tb);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(input string what, input logic [6:0] got,
                                   input logic [6:0] want);
        $display("byte %0d: %s got %h want %h", byte_count, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        term_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
                report_mismatch("unexpected transfer", out_byte, NO_BYTE);
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.code)
                    report_mismatch("out_byte", out_byte, want.code);
                if (last !== want.last)
                    report_mismatch("last", {6'b0, last}, {6'b0, want.last});
            end
            byte_count++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int          done;
        int          pick;
        logic [2:0]  act_v;
        logic [15:0] xv;
        logic [15:0] yv;
        logic [15:0] prev_x;
        logic [15:0] prev_y;
        done   = 0;
        prev_x = '0;
        prev_y = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        foreach (PLOT_ROWS[r])
            issue_command(PLOT_ROWS[r].act, PLOT_ROWS[r].xv, PLOT_ROWS[r].yv,
                          PLOT_ROWS[r].typed_ok, PLOT_ROWS[r].n_typed, PLOT_ROWS[r].typed);
        wait_drain();

        while (done < RAND_ITEMS)
        begin
            quiet <= (done >= 150 && done < 250);
            // hold off the sender until the output has caught up
            if (done == 300)
                wait_drain();
            pick = $urandom_range(0, 99);
            if (pick < 4)
                act_v = 3'($urandom_range(32'(ACT_SPARE_5), 32'(ACT_SPARE_7)));
            else if (pick < 44)
                act_v = ACT_DRAW;
            else if (pick < 72)
                act_v = ACT_MOVE;
            else if (pick < 80)
                act_v = ACT_ALPHA;
            else if (pick < 88)
                act_v = ACT_CLEAR;
            else
                act_v = ACT_PLOT;
            xv = pick_coord(prev_x, X_MAX);
            yv = pick_coord(prev_y, Y_MAX);
            issue_command(act_v, xv, yv, 1'b0, '0, '0);
            prev_x = xv;
            prev_y = yv;
            if (pick >= 4)
                done++;
        end

        wait_drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
